// ----- rtl/efr_pkg.sv -----
package efr_pkg;

  // Default width of the frame byte counter
  localparam int unsigned LENGTH_BITS_DEF = 12;

  // Fixed field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned FRAME_LEN_W = 12;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_BYTE   = 1'b0,
    CFG_ESCAPE_BYTE = 1'b1
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [BYTE_W-1:0] SYNC_BYTE_RST   = 8'h7E;
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'h7D;

  // Codes that follow an escape byte
  localparam logic [BYTE_W-1:0] ESC_CODE_ESCAPE = 8'h01;
  localparam logic [BYTE_W-1:0] ESC_CODE_SYNC   = 8'h02;

  // One result word
  typedef struct packed {
    logic [BYTE_W-1:0]      data_byte;
    logic                   frame_end;
    logic                   checksum_good;
    logic                   escape_fault;
    logic [FRAME_LEN_W-1:0] frame_length;
  } result_t;

endpackage

// ----- rtl/efr_byte_if.sv -----
interface efr_byte_if
  import efr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] raw_byte;

  modport source (output valid, output raw_byte, input ready);
  modport sink   (input valid, input raw_byte, output ready);
endinterface

// ----- rtl/efr_result_if.sv -----
interface efr_result_if
  import efr_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [BYTE_W-1:0]      data_byte;
  logic                   frame_end;
  logic                   checksum_good;
  logic                   escape_fault;
  logic [FRAME_LEN_W-1:0] frame_length;

  modport source (output valid, output data_byte, output frame_end, output checksum_good,
                  output escape_fault, output frame_length, input ready);
  modport sink   (input valid, input data_byte, input frame_end, input checksum_good,
                  input escape_fault, input frame_length, output ready);
endinterface

// ----- rtl/efr_deframe.sv -----
module efr_deframe
  import efr_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] raw_byte,
  input  logic [BYTE_W-1:0] sync_byte,
  input  logic [BYTE_W-1:0] escape_byte,
  output logic              res_valid,
  output result_t           res
);

  logic                   inside_r, inside_nxt;
  logic                   esc_pend_r, esc_pend_nxt;
  logic                   held_valid_r, held_valid_nxt;
  logic [BYTE_W-1:0]      held_value_r, held_value_nxt;
  logic [BYTE_W-1:0]      parity_r, parity_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  logic                   esc_err_r, esc_err_nxt;

  logic                   take;
  logic [BYTE_W-1:0]      take_val;
  logic [LENGTH_BITS+FRAME_LEN_W-1:0] count_ext;

  // Widen or trim the counter to the reported length field
  assign count_ext = {{FRAME_LEN_W{1'b0}}, count_r};

  // Decode one byte and work out the next frame state
  always_comb begin
    inside_nxt     = inside_r;
    esc_pend_nxt   = esc_pend_r;
    held_valid_nxt = held_valid_r;
    held_value_nxt = held_value_r;
    parity_nxt     = parity_r;
    count_nxt      = count_r;
    esc_err_nxt    = esc_err_r;
    take           = 1'b0;
    take_val       = raw_byte;
    res_valid      = 1'b0;
    res            = '0;

    if (step) begin
      if (raw_byte == sync_byte) begin
        // Opening or closing delimiter: clear the frame state either way
        if (inside_r) begin
          res_valid         = 1'b1;
          res.frame_end     = 1'b1;
          res.checksum_good = (parity_r == '0);
          res.escape_fault  = esc_err_r | esc_pend_r;
          res.frame_length  = count_ext[FRAME_LEN_W-1:0];
        end
        inside_nxt     = ~inside_r;
        esc_pend_nxt   = 1'b0;
        held_valid_nxt = 1'b0;
        held_value_nxt = '0;
        parity_nxt     = '0;
        count_nxt      = '0;
        esc_err_nxt    = 1'b0;
      end else if (inside_r) begin
        if (esc_pend_r) begin
          esc_pend_nxt = 1'b0;
          if (raw_byte == ESC_CODE_ESCAPE) begin
            take     = 1'b1;
            take_val = escape_byte;
          end else if (raw_byte == ESC_CODE_SYNC) begin
            take     = 1'b1;
            take_val = sync_byte;
          end else begin
            esc_err_nxt = 1'b1;
          end
        end else if (raw_byte == escape_byte) begin
          esc_pend_nxt = 1'b1;
        end else begin
          take = 1'b1;
        end
      end

      // Fold the unescaped byte in and release the one held before it
      if (take) begin
        parity_nxt = parity_r ^ take_val;
        if (count_r != '1) begin
          count_nxt = count_r + 1'b1;
        end
        if (held_valid_r) begin
          res_valid     = 1'b1;
          res.data_byte = held_value_r;
        end
        held_value_nxt = take_val;
        held_valid_nxt = 1'b1;
      end
    end
  end

  // Hold the frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r     <= 1'b0;
      esc_pend_r   <= 1'b0;
      held_valid_r <= 1'b0;
      held_value_r <= '0;
      parity_r     <= '0;
      count_r      <= '0;
      esc_err_r    <= 1'b0;
    end else begin
      inside_r     <= inside_nxt;
      esc_pend_r   <= esc_pend_nxt;
      held_valid_r <= held_valid_nxt;
      held_value_r <= held_value_nxt;
      parity_r     <= parity_nxt;
      count_r      <= count_nxt;
      esc_err_r    <= esc_err_nxt;
    end
  end

endmodule

// ----- rtl/escaped_frame_receiver.sv -----
// Result path: the link byte that causes a result word is first taken into the input
// register, then decoded, and the result word is presented from the result register.
// Throughput: one link byte per cycle; the input register, the decode logic and the
// result register form a two-stage pipeline that stalls only while a result waits.
// Reset (rst_n, synchronous, active low): pipeline empty, outside any frame, counters and
// checksum cleared, sync byte 0x7E, escape byte 0x7D.
module escaped_frame_receiver
  import efr_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  efr_byte_if.sink             in_ch,
  efr_result_if.source         out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  logic [BYTE_W-1:0] sync_byte_r;
  logic [BYTE_W-1:0] escape_byte_r;

  logic              stage_valid_r;
  logic [BYTE_W-1:0] stage_byte_r;
  logic              advance;
  logic              fire;

  logic              res_valid;
  result_t           res;
  logic              out_valid_r;
  result_t           out_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_byte_r   <= SYNC_BYTE_RST;
      escape_byte_r <= ESCAPE_BYTE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SYNC_BYTE:   sync_byte_r   <= cfg_data;
        CFG_ESCAPE_BYTE: escape_byte_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the pipeline whenever the result register is free or drains this cycle
  assign advance     = ~out_valid_r | out_ch.ready;
  assign fire        = stage_valid_r & advance;
  assign in_ch.ready = ~stage_valid_r | advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_byte_r <= in_ch.raw_byte;
    end
  end

  efr_deframe #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_deframe (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (fire),
    .raw_byte    (stage_byte_r),
    .sync_byte   (sync_byte_r),
    .escape_byte (escape_byte_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire & res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.data_byte     = out_r.data_byte;
  assign out_ch.frame_end     = out_r.frame_end;
  assign out_ch.checksum_good = out_r.checksum_good;
  assign out_ch.escape_fault  = out_r.escape_fault;
  assign out_ch.frame_length  = out_r.frame_length;

endmodule

// ----- verif/tb_escaped_frame_receiver.sv -----
module tb_escaped_frame_receiver;
  timeunit 1ns;
  timeprecision 1ps;
  import efr_pkg::*;

  localparam int unsigned COUNT_MAX    = (1 << LENGTH_BITS_DEF) - 1;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_LEN   = 8;
  localparam int unsigned PHASE_ITEMS  = 105;
  localparam int unsigned HOLD_LEN     = 300;
  localparam int unsigned NUM_PHASES   = 8;

  // Deframer predictor and queue of expected result words
  class frame_scoreboard;
    result_t           expected_words[$];
    logic [BYTE_W-1:0] sync_val;
    logic [BYTE_W-1:0] esc_val;
    bit                in_frame;
    bit                esc_pend;
    bit                held_ok;
    bit                esc_err;
    logic [BYTE_W-1:0] held_val;
    logic [BYTE_W-1:0] parity;
    int unsigned       byte_cnt;
    int unsigned       mismatches;

    function void reset_all();
      sync_val   = SYNC_BYTE_RST;
      esc_val    = ESCAPE_BYTE_RST;
      in_frame   = 1'b0;
      mismatches = 0;
      expected_words.delete();
      clear_frame();
    endfunction

    function void clear_frame();
      esc_pend = 1'b0;
      held_ok  = 1'b0;
      held_val = '0;
      parity   = '0;
      byte_cnt = 0;
      esc_err  = 1'b0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [BYTE_W-1:0] v);
      case (idx)
        CFG_SYNC_BYTE:   sync_val = v;
        CFG_ESCAPE_BYTE: esc_val  = v;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_words.size();
    endfunction

    // Fold one unescaped byte into the checksum; release the held byte
    function void take_byte(logic [BYTE_W-1:0] v);
      result_t w;
      parity = parity ^ v;
      if (byte_cnt < COUNT_MAX) byte_cnt++;
      if (held_ok) begin
        w = '0;
        w.data_byte = held_val;
        expected_words.push_back(w);
      end
      held_val = v;
      held_ok  = 1'b1;
    endfunction

    function void note_link_byte(logic [BYTE_W-1:0] b);
      result_t w;
      if (!in_frame) begin
        if (b == sync_val) begin
          in_frame = 1'b1;
          clear_frame();
        end
      end else if (b == sync_val) begin
        // Closing sync: drop the held checksum byte, report the frame
        w = '0;
        w.frame_end     = 1'b1;
        w.checksum_good = (parity == '0);
        w.escape_fault  = esc_err || esc_pend;
        w.frame_length  = FRAME_LEN_W'(byte_cnt);
        expected_words.push_back(w);
        in_frame = 1'b0;
        clear_frame();
      end else if (esc_pend) begin
        esc_pend = 1'b0;
        if (b == ESC_CODE_ESCAPE) take_byte(esc_val);
        else if (b == ESC_CODE_SYNC) take_byte(sync_val);
        else esc_err = 1'b1;
      end else if (b == esc_val) begin
        esc_pend = 1'b1;
      end else begin
        take_byte(b);
      end
    endfunction

    function void flag_field(string name, int unsigned want, int unsigned got);
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      mismatches++;
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      if (got.data_byte !== want.data_byte)
        flag_field("data_byte", want.data_byte, got.data_byte);
      if (got.frame_end !== want.frame_end)
        flag_field("frame_end", want.frame_end, got.frame_end);
      if (got.checksum_good !== want.checksum_good)
        flag_field("checksum_good", want.checksum_good, got.checksum_good);
      if (got.escape_fault !== want.escape_fault)
        flag_field("escape_fault", want.escape_fault, got.escape_fault);
      if (got.frame_length !== want.frame_length)
        flag_field("frame_length", want.frame_length, got.frame_length);
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  cfg_idx_t          cfg_index;
  logic [BYTE_W-1:0] cfg_data;

  efr_byte_if   in_if ();
  efr_result_if out_if ();

  frame_scoreboard   sb;
  logic [BYTE_W-1:0] link_q[$];
  logic [BYTE_W-1:0] sync_tab[NUM_PHASES];
  logic [BYTE_W-1:0] esc_tab[NUM_PHASES];
  int unsigned       sent_count;
  int unsigned       send_idle_pct;
  int unsigned       stall_pct;
  int unsigned       hold_left;
  bit                hold_req;
  result_t           seen_word;

  escaped_frame_receiver u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // Check result words first, then predict from link bytes taken at this edge
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_word.data_byte     = out_if.data_byte;
      seen_word.frame_end     = out_if.frame_end;
      seen_word.checksum_good = out_if.checksum_good;
      seen_word.escape_fault  = out_if.escape_fault;
      seen_word.frame_length  = out_if.frame_length;
      sb.check_word(seen_word);
    end
    if (rst_n && in_if.valid && in_if.ready) sb.note_link_byte(in_if.raw_byte);
  end

  // Result side: random stalls plus an occasional long hold-off
  initial begin
    out_if.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Send every queued link byte; returns at a falling edge with valid still high
  task automatic send_link_q();
    logic [BYTE_W-1:0] b;
    while (link_q.size() != 0) begin
      b = link_q.pop_front();
      while ($urandom_range(99) < send_idle_pct) begin
        in_if.valid <= 1'b0;
        @(negedge clk);
      end
      in_if.valid    <= 1'b1;
      in_if.raw_byte <= b;
      do @(posedge clk); while (!in_if.ready);
      @(negedge clk);
      sent_count++;
    end
  endtask

  // Stop sending and wait until the block has delivered everything
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_LEN) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [BYTE_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Payload byte biased toward the sync and escape values
  function automatic logic [BYTE_W-1:0] pick_payload();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return sb.sync_val;
    if (r == 1) return sb.esc_val;
    return BYTE_W'($urandom);
  endfunction

  // Queue one content byte with stuffing applied
  function automatic void push_stuffed(logic [BYTE_W-1:0] v);
    if (v == sb.sync_val) begin
      link_q.push_back(sb.esc_val);
      link_q.push_back(ESC_CODE_SYNC);
    end else if (v == sb.esc_val) begin
      link_q.push_back(sb.esc_val);
      link_q.push_back(ESC_CODE_ESCAPE);
    end else begin
      link_q.push_back(v);
    end
  endfunction

  function automatic void push_bad_pair();
    logic [BYTE_W-1:0] c;
    c = BYTE_W'($urandom);
    if (c == ESC_CODE_ESCAPE || c == ESC_CODE_SYNC) c = '0;
    link_q.push_back(sb.esc_val);
    link_q.push_back(c);
  endfunction

  // Queue a whole frame: sync, stuffed payload, checksum, optional faults, sync
  function automatic void push_frame(int unsigned len, bit bad_sum, bit bad_pair,
                                     bit dangling);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] v;
    int unsigned       bad_at;
    sum    = '0;
    bad_at = $urandom_range(len);
    link_q.push_back(sb.sync_val);
    for (int unsigned i = 0; i < len; i++) begin
      if (bad_pair && i == bad_at) push_bad_pair();
      v   = pick_payload();
      sum = sum ^ v;
      push_stuffed(v);
    end
    if (bad_pair && bad_at == len) push_bad_pair();
    if (bad_sum) sum = sum ^ BYTE_W'($urandom_range(1, 255));
    push_stuffed(sum);
    if (dangling) link_q.push_back(sb.esc_val);
    link_q.push_back(sb.sync_val);
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
  endfunction

  // Main sequence
  initial begin
    int unsigned phase_start;
    int unsigned kind;
    bit          paused;
    sb = new();
    sb.reset_all();
    rst_n          <= 1'b0;
    cfg_wr_en      <= 1'b0;
    cfg_index      <= CFG_SYNC_BYTE;
    cfg_data       <= '0;
    in_if.valid    <= 1'b0;
    in_if.raw_byte <= '0;
    sent_count    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    sync_tab = '{SYNC_BYTE_RST, 8'h00, 8'hFF, 8'h55, 8'h01, 8'h02, 8'h00, SYNC_BYTE_RST};
    esc_tab  = '{ESCAPE_BYTE_RST, 8'hFF, 8'h00, 8'h55, 8'h02, 8'h01, 8'h00,
                 ESCAPE_BYTE_RST};
    sync_tab[6] = BYTE_W'($urandom);
    esc_tab[6]  = BYTE_W'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: noise outside a frame, empty frame, both escape codes,
    // bad escape pair, escape right before the closing sync
    link_q = '{8'h00, 8'hFF,
               SYNC_BYTE_RST, SYNC_BYTE_RST,
               SYNC_BYTE_RST, 8'h00, 8'hFF, ESCAPE_BYTE_RST, ESC_CODE_ESCAPE,
               ESCAPE_BYTE_RST, ESC_CODE_SYNC, 8'hFC, SYNC_BYTE_RST,
               SYNC_BYTE_RST, 8'h12, ESCAPE_BYTE_RST, 8'h33, 8'h12, SYNC_BYTE_RST,
               SYNC_BYTE_RST, 8'h55, ESCAPE_BYTE_RST, SYNC_BYTE_RST};
    send_link_q();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(CFG_SYNC_BYTE, sync_tab[p]);
      write_reg(CFG_ESCAPE_BYTE, esc_tab[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase

      // Hold the result side off while bytes keep coming
      if (p == 0 || p == 4) hold_req = 1'b1;

      paused      = 1'b0;
      phase_start = sent_count;
      while (sent_count - phase_start < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 60)      push_frame(pick_len(), $urandom_range(4) == 0, 1'b0, 1'b0);
        else if (kind < 72) push_frame(pick_len(), 1'($urandom_range(1)), 1'b1, 1'b0);
        else if (kind < 82) push_frame(pick_len(), 1'($urandom_range(1)), 1'b0, 1'b1);
        else begin
          repeat ($urandom_range(1, 8)) link_q.push_back(BYTE_W'($urandom));
        end
        send_link_q();
        // Pause the link mid-phase until all results are out
        if ((p == 1 || p == 5) && !paused && sent_count - phase_start > PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/efr_pkg.sv
rtl/efr_byte_if.sv
rtl/efr_result_if.sv
rtl/efr_deframe.sv
rtl/escaped_frame_receiver.sv
verif/tb_escaped_frame_receiver.sv
